// ===== rtl/i2cag_pkg.sv =====
// i2cag_pkg: shared types and constants for the im2col address generator.
// No dependencies; every other file in rtl/ uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package i2cag_pkg;

  localparam int SRC_W       = 36;
  localparam int DST_W       = 40;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 80;
  localparam int TUSER_OUT_W = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_DIMS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERN_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_DIMS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_DIMS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DILATION_DIMS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_DIMS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE   = 3'd7;

  typedef struct packed {
    logic is_bias;
    logic patch_done;
    logic all_done;
  } elem_flags_t;

  localparam int FLAGS_W = $bits(elem_flags_t);

endpackage

`default_nettype wire

// ===== rtl/im2col_address_generator.sv =====
// im2col_address_generator: top level; config registers, walker, queue, datapath.
// Depends on i2cag_pkg, i2cag_walker, i2cag_queue, i2cag_datapath.
//
//  channel   dir  payload                                     handshake
//  s_axis    in   tdata[0] restart                            tvalid/tready
//  m_axis    out  tdata src_index, dst_index; tuser flags;    tvalid/tready
//                 tlast patch_done
//  cfg       in   cfg_index, cfg_data                         cfg_we
//
// One item per cycle sustained while m_axis is ready; an accepted item is written into
// the queue, which is read combinationally, and then passes the four pipeline stages.
// Reset clears the walk counters, queue and pipeline valid bits and loads
// the register defaults. s_axis_tready drops only when the four-entry queue
// is full; m_axis stalls back up through the pipeline into the queue.
`timescale 1ns / 1ps
`default_nettype none

module im2col_address_generator #(
  parameter int DIM_BITS     = 12,
  parameter int KERNEL_BITS  = 4,
  parameter int CHANNEL_BITS = 12,
  localparam int CFG_W = (2*DIM_BITS > CHANNEL_BITS+1) ?
                         ((2*DIM_BITS > 2*KERNEL_BITS) ? 2*DIM_BITS : 2*KERNEL_BITS) :
                         ((CHANNEL_BITS+1 > 2*KERNEL_BITS) ? CHANNEL_BITS+1 : 2*KERNEL_BITS)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [i2cag_pkg::TDATA_IN_W-1:0]    s_axis_tdata,   // restart
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [i2cag_pkg::TDATA_OUT_W-1:0]        m_axis_tdata,   // src_index, dst_index
  output logic [i2cag_pkg::TUSER_OUT_W-1:0]        m_axis_tuser,   // is_pad, is_bias, all_done
  output logic                                     m_axis_tlast,
  input  wire logic                                cfg_we,
  input  wire logic [i2cag_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]                    cfg_data
);

  localparam int CW   = CHANNEL_BITS + 1;
  localparam int RECW = 2*DIM_BITS + CW + 2*KERNEL_BITS + i2cag_pkg::FLAGS_W;

  logic [2*DIM_BITS-1:0]    input_dims, output_dims;
  logic [CW-1:0]            channels;
  logic [2*KERNEL_BITS-1:0] kern_size, stride_dims, pad_dims, dilation_dims;
  logic                     bias_enable;

  logic [DIM_BITS-1:0]      w, h, ow, oh;
  logic [KERNEL_BITS-1:0]   kw, kh;
  logic [CW-1:0]            chans;
  logic [2*DIM_BITS-1:0]    npos;

  logic                     accept, q_full, q_valid, q_pop;
  logic [RECW-1:0]          q_din, q_dout;

  logic [DIM_BITS-1:0]      e_pos_col, e_pos_row, d_pos_col, d_pos_row;
  logic [CW-1:0]            e_chan, d_chan;
  logic [KERNEL_BITS-1:0]   e_krow, e_kcol, d_krow, d_kcol;
  i2cag_pkg::elem_flags_t   e_flags, d_flags, o_flags;

  logic [i2cag_pkg::SRC_W-1:0] o_src;
  logic [i2cag_pkg::DST_W-1:0] o_dst;
  logic                        o_pad;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_dims    <= '0;
      channels      <= CW'(1);
      kern_size     <= {KERNEL_BITS'(1), KERNEL_BITS'(1)};
      stride_dims   <= {KERNEL_BITS'(1), KERNEL_BITS'(1)};
      pad_dims      <= '0;
      dilation_dims <= {KERNEL_BITS'(1), KERNEL_BITS'(1)};
      output_dims   <= '0;
      bias_enable   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cag_pkg::REG_INPUT_DIMS:    input_dims    <= cfg_data[2*DIM_BITS-1:0];
        i2cag_pkg::REG_CHANNELS:      channels      <= cfg_data[CW-1:0];
        i2cag_pkg::REG_KERN_SIZE:     kern_size     <= cfg_data[2*KERNEL_BITS-1:0];
        i2cag_pkg::REG_STRIDE_DIMS:   stride_dims   <= cfg_data[2*KERNEL_BITS-1:0];
        i2cag_pkg::REG_PAD_DIMS:      pad_dims      <= cfg_data[2*KERNEL_BITS-1:0];
        i2cag_pkg::REG_DILATION_DIMS: dilation_dims <= cfg_data[2*KERNEL_BITS-1:0];
        i2cag_pkg::REG_OUTPUT_DIMS:   output_dims   <= cfg_data[2*DIM_BITS-1:0];
        i2cag_pkg::REG_BIAS_ENABLE:   bias_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // zero kernel/output extents and a zero channel count act as one; channel count saturates at 2^CHANNEL_BITS
  always_comb begin
    w  = input_dims[DIM_BITS-1:0];
    h  = input_dims[2*DIM_BITS-1:DIM_BITS];
    kw = (kern_size[KERNEL_BITS-1:0] == '0) ? KERNEL_BITS'(1)
                                            : kern_size[KERNEL_BITS-1:0];
    kh = (kern_size[2*KERNEL_BITS-1:KERNEL_BITS] == '0) ? KERNEL_BITS'(1)
                                            : kern_size[2*KERNEL_BITS-1:KERNEL_BITS];
    ow = (output_dims[DIM_BITS-1:0] == '0) ? DIM_BITS'(1) : output_dims[DIM_BITS-1:0];
    oh = (output_dims[2*DIM_BITS-1:DIM_BITS] == '0) ? DIM_BITS'(1)
                                              : output_dims[2*DIM_BITS-1:DIM_BITS];
    if (channels == '0) begin
      chans = CW'(1);
    end else if (channels[CW-1]) begin
      chans = {1'b1, {CHANNEL_BITS{1'b0}}};
    end else begin
      chans = channels;
    end
  end

  // position count, registered, used by the destination multiply in datapath stage 3
  always_ff @(posedge clk) begin
    npos <= (2*DIM_BITS)'(ow) * (2*DIM_BITS)'(oh);
  end

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  i2cag_walker #(
    .DIM_BITS     (DIM_BITS),
    .KERNEL_BITS  (KERNEL_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .restart     (s_axis_tdata[0]),
    .ow          (ow),
    .oh          (oh),
    .chans       (chans),
    .kw          (kw),
    .kh          (kh),
    .bias_enable (bias_enable),
    .e_pos_col   (e_pos_col),
    .e_pos_row   (e_pos_row),
    .e_chan      (e_chan),
    .e_krow      (e_krow),
    .e_kcol      (e_kcol),
    .e_flags     (e_flags)
  );

  assign q_din = {e_pos_col, e_pos_row, e_chan, e_krow, e_kcol, e_flags};
  assign {d_pos_col, d_pos_row, d_chan, d_krow, d_kcol, d_flags} = q_dout;

  i2cag_queue #(
    .WIDTH (RECW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid)
  );

  i2cag_datapath #(
    .DIM_BITS     (DIM_BITS),
    .KERNEL_BITS  (KERNEL_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_pop),
    .pos_col   (d_pos_col),
    .pos_row   (d_pos_row),
    .chan      (d_chan),
    .krow      (d_krow),
    .kcol      (d_kcol),
    .flags     (d_flags),
    .w         (w),
    .h         (h),
    .sx        (stride_dims[KERNEL_BITS-1:0]),
    .sy        (stride_dims[2*KERNEL_BITS-1:KERNEL_BITS]),
    .pl        (pad_dims[KERNEL_BITS-1:0]),
    .pt        (pad_dims[2*KERNEL_BITS-1:KERNEL_BITS]),
    .dx        (dilation_dims[KERNEL_BITS-1:0]),
    .dy        (dilation_dims[2*KERNEL_BITS-1:KERNEL_BITS]),
    .kw        (kw),
    .kh        (kh),
    .ow        (ow),
    .npos      (npos),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_src   (o_src),
    .out_dst   (o_dst),
    .out_pad   (o_pad),
    .out_flags (o_flags)
  );

  assign m_axis_tdata = {
    {(i2cag_pkg::TDATA_OUT_W - i2cag_pkg::SRC_W - i2cag_pkg::DST_W){1'b0}}, o_dst, o_src
  };
  assign m_axis_tuser = {o_flags.all_done, o_flags.is_bias, o_pad};
  assign m_axis_tlast = o_flags.patch_done;

endmodule

`default_nettype wire

// ===== rtl/i2cag_walker.sv =====
// i2cag_walker: nested position / channel / kernel counters of the walk.
// Classifies each accepted item into an element record. Uses i2cag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cag_walker #(
  parameter int DIM_BITS     = 12,
  parameter int KERNEL_BITS  = 4,
  parameter int CHANNEL_BITS = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire logic                      restart,
  input  wire logic [DIM_BITS-1:0]       ow,
  input  wire logic [DIM_BITS-1:0]       oh,
  input  wire logic [CHANNEL_BITS:0]     chans,
  input  wire logic [KERNEL_BITS-1:0]    kw,
  input  wire logic [KERNEL_BITS-1:0]    kh,
  input  wire logic                      bias_enable,
  output logic [DIM_BITS-1:0]            e_pos_col,
  output logic [DIM_BITS-1:0]            e_pos_row,
  output logic [CHANNEL_BITS:0]          e_chan,
  output logic [KERNEL_BITS-1:0]         e_krow,
  output logic [KERNEL_BITS-1:0]         e_kcol,
  output i2cag_pkg::elem_flags_t         e_flags
);

  logic [DIM_BITS-1:0]     pos_col, pos_row, pos_col_next, pos_row_next;
  logic [CHANNEL_BITS-1:0] chan_count, chan_count_next;
  logic [KERNEL_BITS-1:0]  krow_count, kcol_count, krow_count_next, kcol_count_next;
  logic                    in_bias_phase, in_bias_phase_next;

  logic [DIM_BITS-1:0]     cur_col, cur_row, np_col, np_row;
  logic [CHANNEL_BITS-1:0] cur_chan;
  logic [KERNEL_BITS-1:0]  cur_krow, cur_kcol;
  logic                    cur_bias;
  logic                    col_last, row_last, last_pos;
  logic                    kcol_last, krow_last, chan_last, last_k;

  always_comb begin
    cur_col  = restart ? '0 : pos_col;
    cur_row  = restart ? '0 : pos_row;
    cur_chan = restart ? '0 : chan_count;
    cur_krow = restart ? '0 : krow_count;
    cur_kcol = restart ? '0 : kcol_count;
    cur_bias = restart ? 1'b0 : in_bias_phase;

    col_last  = ({1'b0, cur_col} + 1'b1) >= {1'b0, ow};
    row_last  = ({1'b0, cur_row} + 1'b1) >= {1'b0, oh};
    last_pos  = col_last && row_last;
    kcol_last = ({1'b0, cur_kcol} + 1'b1) >= {1'b0, kw};
    krow_last = ({1'b0, cur_krow} + 1'b1) >= {1'b0, kh};
    chan_last = ({1'b0, cur_chan} + 1'b1) >= chans;
    last_k    = kcol_last && krow_last && chan_last;

    np_col = col_last ? '0 : cur_col + 1'b1;
    np_row = col_last ? (row_last ? '0 : cur_row + 1'b1) : cur_row;

    pos_col_next       = cur_col;
    pos_row_next       = cur_row;
    chan_count_next    = cur_chan;
    krow_count_next    = cur_krow;
    kcol_count_next    = cur_kcol;
    in_bias_phase_next = cur_bias;

    e_pos_col          = cur_col;
    e_pos_row          = cur_row;
    e_chan             = {1'b0, cur_chan};
    e_krow             = cur_krow;
    e_kcol             = cur_kcol;
    e_flags.is_bias    = 1'b0;
    e_flags.patch_done = 1'b0;

    if (cur_bias) begin
      e_chan             = chans;
      e_krow             = '0;
      e_kcol             = '0;
      e_flags.is_bias    = 1'b1;
      e_flags.patch_done = 1'b1;
      in_bias_phase_next = 1'b0;
      pos_col_next       = np_col;
      pos_row_next       = np_row;
    end else begin
      if (kcol_last) begin
        kcol_count_next = '0;
        if (krow_last) begin
          krow_count_next = '0;
          chan_count_next = chan_last ? '0 : cur_chan + 1'b1;
        end else begin
          krow_count_next = cur_krow + 1'b1;
        end
      end else begin
        kcol_count_next = cur_kcol + 1'b1;
      end
      if (last_k) begin
        if (bias_enable) begin
          in_bias_phase_next = 1'b1;
        end else begin
          e_flags.patch_done = 1'b1;
          pos_col_next       = np_col;
          pos_row_next       = np_row;
        end
      end
    end
    e_flags.all_done = e_flags.patch_done && last_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_col       <= '0;
      pos_row       <= '0;
      chan_count    <= '0;
      krow_count    <= '0;
      kcol_count    <= '0;
      in_bias_phase <= 1'b0;
    end else if (accept) begin
      pos_col       <= pos_col_next;
      pos_row       <= pos_row_next;
      chan_count    <= chan_count_next;
      krow_count    <= krow_count_next;
      kcol_count    <= kcol_count_next;
      in_bias_phase <= in_bias_phase_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/i2cag_queue.sv =====
// i2cag_queue: short FIFO of element records between walker and datapath.
// Depth from i2cag_pkg; record width is a parameter.
`timescale 1ns / 1ps
`default_nettype none

module i2cag_queue #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  valid
);

  logic [WIDTH-1:0]                mem [i2cag_pkg::QUEUE_DEPTH];
  logic [i2cag_pkg::QPTR_W-1:0]    wptr, rptr;
  logic [i2cag_pkg::QPTR_W:0]      count;
  logic                            do_pop;

  assign valid  = count != '0;
  assign full   = count == (i2cag_pkg::QPTR_W+1)'(i2cag_pkg::QUEUE_DEPTH);
  assign dout   = mem[rptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");
  assert property (@(posedge clk) disable iff (rst)
    valid |-> (wptr - rptr) == count[i2cag_pkg::QPTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== rtl/i2cag_datapath.sv =====
// i2cag_datapath: four-stage address pipeline, last stage is the output register.
// Turns element records into source/destination indexes. Uses i2cag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cag_datapath #(
  parameter int DIM_BITS     = 12,
  parameter int KERNEL_BITS  = 4,
  parameter int CHANNEL_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [DIM_BITS-1:0]           pos_col,
  input  wire logic [DIM_BITS-1:0]           pos_row,
  input  wire logic [CHANNEL_BITS:0]         chan,
  input  wire logic [KERNEL_BITS-1:0]        krow,
  input  wire logic [KERNEL_BITS-1:0]        kcol,
  input  wire i2cag_pkg::elem_flags_t        flags,
  input  wire logic [DIM_BITS-1:0]           w,
  input  wire logic [DIM_BITS-1:0]           h,
  input  wire logic [KERNEL_BITS-1:0]        sx,
  input  wire logic [KERNEL_BITS-1:0]        sy,
  input  wire logic [KERNEL_BITS-1:0]        pl,
  input  wire logic [KERNEL_BITS-1:0]        pt,
  input  wire logic [KERNEL_BITS-1:0]        dx,
  input  wire logic [KERNEL_BITS-1:0]        dy,
  input  wire logic [KERNEL_BITS-1:0]        kw,
  input  wire logic [KERNEL_BITS-1:0]        kh,
  input  wire logic [DIM_BITS-1:0]           ow,
  input  wire logic [2*DIM_BITS-1:0]         npos,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [i2cag_pkg::SRC_W-1:0]        out_src,
  output logic [i2cag_pkg::DST_W-1:0]        out_dst,
  output logic                               out_pad,
  output i2cag_pkg::elem_flags_t             out_flags
);

  localparam int CW  = CHANNEL_BITS + 1;
  localparam int PW  = DIM_BITS + KERNEL_BITS;
  localparam int XW  = DIM_BITS + 2*KERNEL_BITS + 2;
  localparam int CRW = CW + KERNEL_BITS + 1;
  localparam int RW  = CRW + KERNEL_BITS + 1;
  localparam int S1W = CW + DIM_BITS + 1;
  localparam int DPW = RW + 2*DIM_BITS;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1
  logic [PW-1:0]            px1, py1;
  logic [2*KERNEL_BITS-1:0] kx1, ky1;
  logic [CRW-1:0]           cr1;
  logic [2*DIM_BITS-1:0]    prow1;
  logic [DIM_BITS-1:0]      col1;
  logic [CW-1:0]            chan1;
  logic [KERNEL_BITS-1:0]   kcol1;
  i2cag_pkg::elem_flags_t   flags1;
  // stage 2
  logic signed [XW-1:0]     x2, y2;
  logic [RW-1:0]            row2;
  logic [2*DIM_BITS:0]      posoff2;
  logic [CW-1:0]            chan2;
  i2cag_pkg::elem_flags_t   flags2;
  // stage 3
  logic                     pad3;
  logic [S1W-1:0]           s13;
  logic [DIM_BITS-1:0]      x3;
  logic [DPW-1:0]           dprod3;
  logic [2*DIM_BITS:0]      posoff3;
  i2cag_pkg::elem_flags_t   flags3;

  logic signed [XW-1:0]     w_s, h_s;

  assign w_s = $signed(XW'(w));
  assign h_s = $signed(XW'(h));

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      px1    <= PW'(pos_col) * PW'(sx);
      py1    <= PW'(pos_row) * PW'(sy);
      kx1    <= (2*KERNEL_BITS)'(kcol) * (2*KERNEL_BITS)'(dx);
      ky1    <= (2*KERNEL_BITS)'(krow) * (2*KERNEL_BITS)'(dy);
      cr1    <= CRW'(CRW'(chan) * CRW'(kh)) + CRW'(krow);
      prow1  <= (2*DIM_BITS)'(pos_row) * (2*DIM_BITS)'(ow);
      col1   <= pos_col;
      chan1  <= chan;
      kcol1  <= kcol;
      flags1 <= flags;
    end
    if (rdy2) begin
      x2      <= $signed(XW'(px1)) + $signed(XW'(kx1)) - $signed(XW'(pl));
      y2      <= $signed(XW'(py1)) + $signed(XW'(ky1)) - $signed(XW'(pt));
      row2    <= RW'(RW'(cr1) * RW'(kw)) + RW'(kcol1);
      posoff2 <= (2*DIM_BITS+1)'(prow1) + (2*DIM_BITS+1)'(col1);
      chan2   <= chan1;
      flags2  <= flags1;
    end
    if (rdy3) begin
      pad3    <= !flags2.is_bias &&
                 (x2[XW-1] || y2[XW-1] || (x2 >= w_s) || (y2 >= h_s));
      s13     <= S1W'(S1W'(chan2) * S1W'(h)) + S1W'(y2[DIM_BITS-1:0]);
      x3      <= x2[DIM_BITS-1:0];
      dprod3  <= DPW'(row2) * DPW'(npos);
      posoff3 <= posoff2;
      flags3  <= flags2;
    end
    if (rdy4) begin
      out_src   <= (pad3 || flags3.is_bias) ? '0 :
                   i2cag_pkg::SRC_W'(s13) * i2cag_pkg::SRC_W'(w) +
                   i2cag_pkg::SRC_W'(x3);
      out_dst   <= i2cag_pkg::DST_W'(dprod3) + i2cag_pkg::DST_W'(posoff3);
      out_pad   <= pad3;
      out_flags <= flags3;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_pad || out_flags.is_bias) |-> out_src == '0)
    else $error("nonzero source index on pad or bias element");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_flags.is_bias |-> !out_pad && out_flags.patch_done)
    else $error("bias element not closing its patch");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_flags.all_done |-> out_flags.patch_done)
    else $error("walk end without patch end");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_dst))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// testbench: self-checking bench for im2col_address_generator (stream in/out, cfg port).
// Depends on rtl/i2cag_pkg.sv and rtl/im2col_address_generator.sv; predicts each element
// descriptor in-bench and compares it with the output stream in order.
`timescale 1ns / 1ps

module testbench;

  localparam int DIM_MASK   = 'hFFF;
  localparam int KERN_MASK  = 'hF;
  localparam int CHAN_MASK  = 'hFFF;
  localparam int MAX_CHANS  = 4096;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 750;

  typedef struct packed {
    logic [i2cag_pkg::SRC_W-1:0] src_index;
    logic [i2cag_pkg::DST_W-1:0] dst_index;
    logic                        is_pad;
    logic                        is_bias;
    logic                        patch_done;
    logic                        all_done;
  } elem_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [i2cag_pkg::TDATA_IN_W-1:0]  s_axis_tdata = '0;    // restart
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [i2cag_pkg::TDATA_OUT_W-1:0] m_axis_tdata;         // src_index, dst_index
  logic [i2cag_pkg::TUSER_OUT_W-1:0] m_axis_tuser;         // is_pad, is_bias, all_done
  logic                              m_axis_tlast;
  logic                              cfg_we = 1'b0;
  logic [i2cag_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [23:0]                       cfg_data = '0;

  im2col_address_generator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // register shadow, reset values
  logic [23:0] in_dims_q   = '0;
  logic [12:0] chans_q     = 13'd1;
  logic [7:0]  kernel_q    = 8'h11;
  logic [7:0]  stride_q    = 8'h11;
  logic [7:0]  pad_q       = 8'h00;
  logic [7:0]  dilation_q  = 8'h11;
  logic [23:0] odims_q     = '0;
  logic        bias_en_q   = 1'b0;

  // walk position
  int unsigned walk_col, walk_row, walk_chan, walk_krow, walk_kcol;
  bit          walk_bias;

  bit    req_restarts[$];
  elem_t elems_due[$];
  bit    noisy = 1'b0;
  int    send_gap;
  int    stall_left;
  int    mismatches;
  int    quiet_cycles;

  task automatic advance_position(input int unsigned ow, input int unsigned oh);
    walk_bias = 1'b0;
    if (walk_col + 1 >= ow) begin
      walk_col = 0;
      if (walk_row + 1 >= oh) walk_row = 0;
      else walk_row = (walk_row + 1) & DIM_MASK;
    end else begin
      walk_col = (walk_col + 1) & DIM_MASK;
    end
  endtask

  task automatic next_element(input bit restart);
    int unsigned w, h, kw, kh, sx, sy, pl, pt, dx, dy, ow, oh, ch;
    longint x, y;
    longint unsigned npos, posoff, row, src;
    bit lastpos, lastk;
    elem_t e;
    w  = in_dims_q[11:0];
    h  = in_dims_q[23:12];
    kw = (kernel_q[3:0] == 0) ? 1 : kernel_q[3:0];
    kh = (kernel_q[7:4] == 0) ? 1 : kernel_q[7:4];
    sx = stride_q[3:0];
    sy = stride_q[7:4];
    pl = pad_q[3:0];
    pt = pad_q[7:4];
    dx = dilation_q[3:0];
    dy = dilation_q[7:4];
    ow = (odims_q[11:0] == 0) ? 1 : odims_q[11:0];
    oh = (odims_q[23:12] == 0) ? 1 : odims_q[23:12];
    ch = (chans_q == 0) ? 1 : chans_q;
    if (ch > MAX_CHANS) ch = MAX_CHANS;
    npos = 64'(ow) * oh;
    if (restart) begin
      walk_col = 0; walk_row = 0; walk_chan = 0; walk_krow = 0; walk_kcol = 0;
      walk_bias = 1'b0;
    end
    posoff = 64'(walk_row) * ow + walk_col;
    lastpos = (walk_col + 1 >= ow) && (walk_row + 1 >= oh);
    e = '0;
    src = 0;
    if (walk_bias) begin
      e.is_bias = 1'b1;
      e.patch_done = 1'b1;
      row = 64'(ch) * kh * kw;
      advance_position(ow, oh);
    end else begin
      x = longint'(walk_col) * longint'(sx) - longint'(pl) + longint'(walk_kcol) * longint'(dx);
      y = longint'(walk_row) * longint'(sy) - longint'(pt) + longint'(walk_krow) * longint'(dy);
      lastk = (walk_kcol + 1 >= kw) && (walk_krow + 1 >= kh) && (walk_chan + 1 >= ch);
      row = (64'(walk_chan) * kh + walk_krow) * kw + walk_kcol;
      if (x < 0 || y < 0 || x >= longint'(w) || y >= longint'(h)) e.is_pad = 1'b1;
      else src = (64'(walk_chan) * h + 64'(y)) * w + 64'(x);
      if (walk_kcol + 1 >= kw) begin
        walk_kcol = 0;
        if (walk_krow + 1 >= kh) begin
          walk_krow = 0;
          if (walk_chan + 1 >= ch) walk_chan = 0;
          else walk_chan = (walk_chan + 1) & CHAN_MASK;
        end else begin
          walk_krow = (walk_krow + 1) & KERN_MASK;
        end
      end else begin
        walk_kcol = (walk_kcol + 1) & KERN_MASK;
      end
      if (lastk) begin
        if (bias_en_q) begin
          walk_bias = 1'b1;
        end else begin
          e.patch_done = 1'b1;
          advance_position(ow, oh);
        end
      end
    end
    e.all_done = e.patch_done && lastpos;
    e.src_index = src[i2cag_pkg::SRC_W-1:0];
    e.dst_index = i2cag_pkg::DST_W'(row * npos + posoff);
    elems_due.push_back(e);
  endtask

  // stimulus side
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) next_element(s_axis_tdata[0]);
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (req_restarts.size() != 0) begin
        s_axis_tdata  <= {{(i2cag_pkg::TDATA_IN_W-1){1'b0}}, req_restarts.pop_front()};
        s_axis_tvalid <= 1'b1;
        if (noisy && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 3);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic flag_mismatch(input string field, input longint unsigned want,
                               input longint unsigned got);
    if (mismatches < 10)
      $display("mismatch %s: expected 0x%0h, got 0x%0h at %0t", field, want, got, $realtime);
    mismatches++;
  endtask

  task automatic check_elem();
    elem_t e;
    if (elems_due.size() == 0) begin
      if (mismatches < 10) $display("unexpected element at %0t", $realtime);
      mismatches++;
    end else begin
      e = elems_due.pop_front();
      if (m_axis_tdata[i2cag_pkg::SRC_W-1:0] !== e.src_index)
        flag_mismatch("src_index", e.src_index, m_axis_tdata[i2cag_pkg::SRC_W-1:0]);
      if (m_axis_tdata[i2cag_pkg::SRC_W+i2cag_pkg::DST_W-1:i2cag_pkg::SRC_W] !== e.dst_index)
        flag_mismatch("dst_index", e.dst_index,
                      m_axis_tdata[i2cag_pkg::SRC_W+i2cag_pkg::DST_W-1:i2cag_pkg::SRC_W]);
      if (m_axis_tuser[0] !== e.is_pad)     flag_mismatch("is_pad", e.is_pad, m_axis_tuser[0]);
      if (m_axis_tuser[1] !== e.is_bias)    flag_mismatch("is_bias", e.is_bias, m_axis_tuser[1]);
      if (m_axis_tlast !== e.patch_done)
        flag_mismatch("patch_done", e.patch_done, m_axis_tlast);
      if (m_axis_tuser[2] !== e.all_done)   flag_mismatch("all_done", e.all_done, m_axis_tuser[2]);
    end
  endtask

  // result side
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_elem();
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (noisy && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_restarts.size() == 0 && elems_due.size() == 0 && !s_axis_tvalid) ||
        (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [i2cag_pkg::CFG_IDX_W-1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      i2cag_pkg::REG_INPUT_DIMS:    in_dims_q  = val;
      i2cag_pkg::REG_CHANNELS:      chans_q    = val[12:0];
      i2cag_pkg::REG_KERN_SIZE:     kernel_q   = val[7:0];
      i2cag_pkg::REG_STRIDE_DIMS:   stride_q   = val[7:0];
      i2cag_pkg::REG_PAD_DIMS:      pad_q      = val[7:0];
      i2cag_pkg::REG_DILATION_DIMS: dilation_q = val[7:0];
      i2cag_pkg::REG_OUTPUT_DIMS:   odims_q    = val;
      i2cag_pkg::REG_BIAS_ENABLE:   bias_en_q  = val[0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [23:0] in_dims, input logic [12:0] chans,
                             input logic [7:0] kernel, input logic [7:0] stride,
                             input logic [7:0] pad, input logic [7:0] dilation,
                             input logic [23:0] odims, input logic bias);
    write_reg(i2cag_pkg::REG_INPUT_DIMS, in_dims);
    write_reg(i2cag_pkg::REG_CHANNELS, 24'(chans));
    write_reg(i2cag_pkg::REG_KERN_SIZE, 24'(kernel));
    write_reg(i2cag_pkg::REG_STRIDE_DIMS, 24'(stride));
    write_reg(i2cag_pkg::REG_PAD_DIMS, 24'(pad));
    write_reg(i2cag_pkg::REG_DILATION_DIMS, 24'(dilation));
    write_reg(i2cag_pkg::REG_OUTPUT_DIMS, odims);
    write_reg(i2cag_pkg::REG_BIAS_ENABLE, 24'(bias));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // checked between edges so that driver updates have settled
  task automatic drain();
    while (req_restarts.size() != 0 || elems_due.size() != 0 || s_axis_tvalid) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int unsigned pick(input int unsigned small_hi, input int unsigned top);
    return ($urandom_range(0, 7) == 0) ? top : $urandom_range(0, small_hi);
  endfunction

  initial begin
    int sent;
    int n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: every element closes the only patch
    req_restarts.push_back(1'b0);
    req_restarts.push_back(1'b1);
    drain();

    // 4x3 input, 2 channels, 2x2 kernel, pad 1, bias on
    load_config(24'h003004, 13'd2, 8'h22, 8'h11, 8'h11, 8'h11, 24'h002002, 1'b1);
    req_restarts.push_back(1'b1);
    repeat (11) req_restarts.push_back(1'b0);
    drain();

    // leave a bias element pending, then disable bias
    load_config(24'h002002, 13'd1, 8'h11, 8'h11, 8'h00, 8'h11, 24'h002002, 1'b1);
    req_restarts.push_back(1'b1);
    drain();
    write_reg(i2cag_pkg::REG_BIAS_ENABLE, 24'd0);
    @(posedge clk);
    cfg_we <= 1'b0;
    req_restarts.push_back(1'b0);
    req_restarts.push_back(1'b0);
    drain();

    // all fields at maximum, channel count saturates
    load_config(24'hFFFFFF, 13'h1FFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF, 1'b1);
    req_restarts.push_back(1'b1);
    repeat (3) req_restarts.push_back(1'b0);
    drain();

    // all zero extents, counters left beyond their limits
    load_config(24'h0, 13'd0, 8'h00, 8'h00, 8'h00, 8'h00, 24'h0, 1'b0);
    repeat (4) req_restarts.push_back(1'b0);
    drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      noisy = (sent < RANDOM_ITEMS - 150) && ($urandom_range(0, 3) != 0);
      load_config({12'(pick(8, 4095)), 12'(pick(8, 4095))},
                  13'(pick(3, $urandom_range(0, 1) ? 4096 : 8191)),
                  {4'(pick(3, 15)), 4'(pick(3, 15))},
                  {4'(pick(3, 15)), 4'(pick(3, 15))},
                  {4'(pick(2, 15)), 4'(pick(2, 15))},
                  {4'(pick(3, 15)), 4'(pick(3, 15))},
                  {12'(pick(4, 4095)), 12'(pick(4, 4095))},
                  1'($urandom_range(0, 1)));
      n = $urandom_range(20, 90);
      req_restarts.push_back(1'($urandom_range(0, 1)));
      repeat (n - 1) req_restarts.push_back($urandom_range(0, 29) == 0);
      sent += n;
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && elems_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
